// ===== rtl/sp_pkg.sv =====
// sp_pkg: shared types and constants of the sandpile toppling automaton
// depends on: nothing
package sp_pkg;

    typedef enum logic {
        OP_ADD     = 1'b0,
        OP_TOPPLE  = 1'b1
    } op_t;

    localparam int unsigned HEIGHT_W    = 4;
    localparam int unsigned LOSS_W      = 3;
    localparam int unsigned ROW_W       = 5;
    localparam int unsigned COUNT_W     = 11;
    localparam int unsigned TOTAL_W     = 14;
    localparam int unsigned STAT_W      = 32;

    localparam logic [HEIGHT_W-1:0] TOPPLE_LOSS = 4'd4;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 4'd15;
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = 11'h7FF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = 14'h3FFF;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic en;
        op_t  op;
    } cell_ctrl_t;

    // what travels with a beat through the reduction tree
    typedef struct packed {
        op_t  op;
        logic gain;
    } item_tag_t;

    function automatic logic [STAT_W-1:0] sat_add32(input logic [STAT_W-1:0] a,
                                                    input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

endpackage

// ===== rtl/sp_cell.sv =====
// sp_cell: one grid cell, holds height and critical mark, topples or takes a grain
// depends on: sp_pkg
module sp_cell import sp_pkg::*; #(
    parameter int EDGES = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic               hit,
    input  logic [3:0]         nbr_mark,
    output logic               mark,
    output logic [LOSS_W-1:0]  loss,
    output logic               gain
);

    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                mark_reg, mark_next;
    logic [LOSS_W-1:0]   loss_reg, loss_next;

    logic [HEIGHT_W-1:0] h_dec, h_top, h_add;
    logic [2:0]          incoming;
    logic [HEIGHT_W:0]   h_sum;
    logic [LOSS_W-1:0]   overflow;

    always_comb begin
        if (mark_reg) begin
            h_dec = (height_reg >= TOPPLE_LOSS) ? height_reg - TOPPLE_LOSS : '0;
        end else begin
            h_dec = height_reg;
        end
        incoming = 3'(nbr_mark[0]) + 3'(nbr_mark[1]) + 3'(nbr_mark[2]) + 3'(nbr_mark[3]);
        h_sum    = {1'b0, h_dec} + 5'(incoming);
        if (h_sum > {1'b0, HEIGHT_MAX}) begin
            overflow = LOSS_W'(h_sum - {1'b0, HEIGHT_MAX});
            h_top    = HEIGHT_MAX;
        end else begin
            overflow = '0;
            h_top    = h_sum[HEIGHT_W-1:0];
        end

        gain  = hit && (ctrl.op == OP_ADD) && (height_reg != HEIGHT_MAX);
        h_add = gain ? height_reg + 4'd1 : height_reg;

        unique case (ctrl.op)
            OP_ADD: begin
                height_next = h_add;
                mark_next   = mark_reg | (hit && (h_add >= TOPPLE_LOSS));
                loss_next   = '0;
            end
            OP_TOPPLE: begin
                height_next = h_top;
                mark_next   = (h_top >= TOPPLE_LOSS);
                loss_next   = (mark_reg ? LOSS_W'(EDGES) : '0) + overflow;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= '0;
            mark_reg   <= 1'b0;
        end else if (ctrl.en) begin
            height_reg <= height_next;
            mark_reg   <= mark_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            loss_reg <= loss_next;
        end
    end

    assign mark = mark_reg;
    assign loss = loss_reg;

endmodule

// ===== rtl/sp_count_tree.sv =====
// sp_count_tree: registered adder tree over all cells, one level per stage
// sums critical marks and lost grains; depends on: sp_pkg
module sp_count_tree import sp_pkg::*; #(
    parameter int N  = 1024,
    parameter int CW = 11,
    parameter int LW = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  item_tag_t          in_tag,
    input  logic               leaf_mark [N],
    input  logic [LOSS_W-1:0]  leaf_loss [N],
    output logic               adv,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [CW-1:0]      out_count,
    output logic [LW-1:0]      out_loss,
    output item_tag_t          out_tag
);

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    logic [L-1:0]  valid_reg;
    item_tag_t     tag_reg [L];
    logic [CW-1:0] node_c_reg [P-1];
    logic [LW-1:0] node_l_reg [P-1];
    logic [CW-1:0] leaf_c [P];
    logic [LW-1:0] leaf_l [P];

    assign adv = !valid_reg[L-1] || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[L-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < L; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    for (genvar j = 0; j < P; j++) begin : g_leaf_in
        if (j < N) begin : g_real
            assign leaf_c[j] = CW'(leaf_mark[j]);
            assign leaf_l[j] = LW'(leaf_loss[j]);
        end else begin : g_pad
            assign leaf_c[j] = '0;
            assign leaf_l[j] = '0;
        end
    end

    for (genvar i = 0; i < P - 1; i++) begin : g_node
        localparam int A = 2 * i + 1;
        localparam int B = 2 * i + 2;
        if (A >= P - 1) begin : g_bottom
            always_ff @(posedge aclk) begin
                if (adv) begin
                    node_c_reg[i] <= leaf_c[A-(P-1)] + leaf_c[B-(P-1)];
                    node_l_reg[i] <= leaf_l[A-(P-1)] + leaf_l[B-(P-1)];
                end
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                if (adv) begin
                    node_c_reg[i] <= node_c_reg[A] + node_c_reg[B];
                    node_l_reg[i] <= node_l_reg[A] + node_l_reg[B];
                end
            end
        end
    end

    assign out_valid = valid_reg[L-1];
    assign out_count = node_c_reg[0];
    assign out_loss  = node_l_reg[0];
    assign out_tag   = tag_reg[L-1];

endmodule

// ===== rtl/sandpile_toppling_automaton.sv =====
// sandpile_toppling_automaton: top level, cell grid, reduction tree and statistics stage
// depends on: sp_pkg, sp_cell, sp_count_tree
//
// input channel s_*: one beat is either an add (one grain at s_row, s_col) or a
// topple (one synchronous toppling step over the whole grid). every beat gives
// exactly one beat on m_*: critical cell count, grain total and, when an
// avalanche starts after a quiet spell, an avalanche record.
// the grid is a row of cells per row, each cell reading its four neighbors'
// marks, so the whole grid updates in the cycle a beat is taken.
// path: an input beat reaches m_valid through the grid registers, each level of
// the adder tree that counts marks and lost grains, and the output registers.
// throughput: one beat per cycle while m_ready is high.
// cfg_wr_en/cfg_wr_data write the avalanche threshold; write it only while idle.
// reset (aresetn low, synchronous) clears all heights, marks, totals, counters
// and the threshold; the grid is ready as soon as reset is released.
// when m_ready is low the result holds on m_*; the tree keeps shifting until its
// last stage holds a beat, then it stops as a whole, the grid stage takes at
// most one more beat and s_ready drops.
module sandpile_toppling_automaton import sp_pkg::*; #(
    parameter int GRID_SIZE = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [ROW_W-1:0]    s_row,
    input  logic [ROW_W-1:0]    s_col,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COUNT_W-1:0]  m_critical_count,
    output logic [TOTAL_W-1:0]  m_grain_total,
    output logic                m_record_valid,
    output logic [STAT_W-1:0]   m_record_duration,
    output logic [STAT_W-1:0]   m_record_area,
    output logic [STAT_W-1:0]   m_record_quiet
);

    localparam int G     = GRID_SIZE;
    localparam int CELLS = G * G;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int LW    = $clog2(6 * CELLS + 1);

    logic              accept;
    logic              grid_adv;
    logic              grid_valid_reg;
    item_tag_t         grid_tag_reg;
    cell_ctrl_t        cell_ctrl;
    logic [G-1:0]      row_hit, col_hit;
    logic              mark_grid [G+2][G+2];
    logic              mark_flat [CELLS];
    logic [LOSS_W-1:0] loss_flat [CELLS];
    logic [CELLS-1:0]  gain_vec;

    logic              tree_adv;
    logic              tree_valid;
    logic [CW-1:0]     tree_count;
    logic [LW-1:0]     tree_loss;
    item_tag_t         tree_tag;
    logic              fin_adv;

    logic [COUNT_W-1:0] threshold_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [STAT_W-1:0]  duration_reg, duration_next;
    logic [STAT_W-1:0]  area_reg, area_next;
    logic [STAT_W-1:0]  quiet_reg, quiet_next;
    logic [COUNT_W-1:0] count_sat;
    logic               record;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               record_reg;
    logic [STAT_W-1:0]  rec_dur_reg, rec_area_reg, rec_quiet_reg;

    // grid stage
    assign grid_adv = !grid_valid_reg || tree_adv;
    assign s_ready  = grid_adv;
    assign accept   = s_valid && grid_adv;

    assign cell_ctrl = '{en: accept, op: op_t'(s_op)};

    for (genvar r = 0; r < G; r++) begin : g_hit
        assign row_hit[r] = (32'(s_row) == r);
        assign col_hit[r] = (32'(s_col) == r);
    end

    // zero border around the grid
    for (genvar i = 0; i < G + 2; i++) begin : g_border_tb
        assign mark_grid[0][i]   = 1'b0;
        assign mark_grid[G+1][i] = 1'b0;
    end
    for (genvar i = 1; i < G + 1; i++) begin : g_border_lr
        assign mark_grid[i][0]   = 1'b0;
        assign mark_grid[i][G+1] = 1'b0;
    end

    for (genvar r = 0; r < G; r++) begin : g_row
        for (genvar c = 0; c < G; c++) begin : g_col
            localparam int IDX   = r * G + c;
            localparam int EDGES = (r == 0 ? 1 : 0) + (r == G - 1 ? 1 : 0)
                                 + (c == 0 ? 1 : 0) + (c == G - 1 ? 1 : 0);
            sp_cell #(
                .EDGES(EDGES)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .hit      (row_hit[r] && col_hit[c]),
                .nbr_mark ({mark_grid[r+2][c+1], mark_grid[r][c+1],
                            mark_grid[r+1][c+2], mark_grid[r+1][c]}),
                .mark     (mark_flat[IDX]),
                .loss     (loss_flat[IDX]),
                .gain     (gain_vec[IDX])
            );
            assign mark_grid[r+1][c+1] = mark_flat[IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_valid_reg <= 1'b0;
        end else if (grid_adv) begin
            grid_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            grid_tag_reg <= '{op: op_t'(s_op), gain: |gain_vec};
        end
    end

    // reduction
    sp_count_tree #(
        .N (CELLS),
        .CW(CW),
        .LW(LW)
    ) u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (grid_valid_reg),
        .in_tag    (grid_tag_reg),
        .leaf_mark (mark_flat),
        .leaf_loss (loss_flat),
        .adv       (tree_adv),
        .out_ready (fin_adv),
        .out_valid (tree_valid),
        .out_count (tree_count),
        .out_loss  (tree_loss),
        .out_tag   (tree_tag)
    );

    // statistics and output stage
    assign fin_adv = !m_valid_reg || m_ready;

    always_comb begin
        count_sat = (32'(tree_count) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(tree_count);

        unique case (tree_tag.op)
            OP_ADD: begin
                total_next = (tree_tag.gain && total_reg != TOTAL_MAX)
                           ? total_reg + 14'd1 : total_reg;
            end
            OP_TOPPLE: begin
                total_next = (32'(total_reg) > 32'(tree_loss))
                           ? total_reg - TOTAL_W'(tree_loss) : '0;
            end
        endcase

        record        = 1'b0;
        duration_next = duration_reg;
        area_next     = area_reg;
        quiet_next    = quiet_reg;
        if (count_sat > threshold_reg) begin
            if (quiet_reg != '0) begin
                record        = 1'b1;
                quiet_next    = '0;
                duration_next = 32'd1;
                area_next     = 32'(count_sat);
            end else begin
                duration_next = sat_add32(duration_reg, 32'd1);
                area_next     = sat_add32(area_reg, 32'(count_sat));
            end
        end else begin
            quiet_next = sat_add32(quiet_reg, 32'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            m_valid_reg   <= 1'b0;
            total_reg     <= '0;
            duration_reg  <= '0;
            area_reg      <= '0;
            quiet_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            if (fin_adv) begin
                m_valid_reg <= tree_valid;
            end
            if (fin_adv && tree_valid) begin
                total_reg    <= total_next;
                duration_reg <= duration_next;
                area_reg     <= area_next;
                quiet_reg    <= quiet_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_adv && tree_valid) begin
            count_reg     <= count_sat;
            out_total_reg <= total_next;
            record_reg    <= record;
            rec_dur_reg   <= record ? duration_reg : '0;
            rec_area_reg  <= record ? area_reg : '0;
            rec_quiet_reg <= record ? quiet_reg : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_critical_count  = count_reg;
    assign m_grain_total     = out_total_reg;
    assign m_record_valid    = record_reg;
    assign m_record_duration = rec_dur_reg;
    assign m_record_area     = rec_area_reg;
    assign m_record_quiet    = rec_quiet_reg;

endmodule

// ===== rtl/sp_checker.sv =====
// sp_checker: port-level assertions on the result channel of the automaton
// bound to sandpile_toppling_automaton; depends on: nothing
module sp_checker #(
    parameter int GRID_SIZE = 32
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_critical_count,
    input logic [13:0] m_grain_total,
    input logic        m_record_valid,
    input logic [31:0] m_record_duration,
    input logic [31:0] m_record_area,
    input logic [31:0] m_record_quiet
);

    // stalled beat holds its count, grain total, record flag and quiet field
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_critical_count)
            && $stable(m_grain_total) && $stable(m_record_valid)
            && $stable(m_record_quiet))
        else $error("stalled result beat changed");

    a_no_record_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_valid |->
            m_record_duration == '0 && m_record_area == '0 && m_record_quiet == '0)
        else $error("record fields nonzero without a record");

    // a record only starts an avalanche after a quiet spell
    a_record_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_valid |-> m_record_quiet != '0 && m_critical_count != '0)
        else $error("record without quiet spell or activity");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_critical_count) <= GRID_SIZE * GRID_SIZE)
        else $error("critical count beyond grid size");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sandpile_toppling_automaton sp_checker #(.GRID_SIZE(GRID_SIZE)) u_sp_checker (.*);

// ===== tb/tb.sv =====
// tb: self-checking bench for sandpile_toppling_automaton, grid model scoreboard plus drivers
// depends on: sp_pkg, sandpile_toppling_automaton
// adds and topples go in with random gaps and stalls, results are checked in order
import sp_pkg::*;

localparam int GRID_N = 32;

typedef struct {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic               rec;
    logic [STAT_W-1:0]  dur;
    logic [STAT_W-1:0]  area;
    logic [STAT_W-1:0]  quiet;
} grid_tally_t;

class pile_scoreboard;
    bit [HEIGHT_W-1:0]  height [GRID_N*GRID_N];
    bit                 mark [GRID_N*GRID_N];
    bit [TOTAL_W-1:0]   grains;
    bit [STAT_W-1:0]    run_len;
    bit [STAT_W-1:0]    run_area;
    bit [STAT_W-1:0]    quiet;
    bit [COUNT_W-1:0]   threshold;
    grid_tally_t        tally_q [$];
    int unsigned        n_checked;
    int unsigned        n_errors;
    int unsigned        n_records;
    int unsigned        n_topples;
    int unsigned        peak_count;

    function new();
        foreach (height[i]) begin
            height[i] = '0;
            mark[i] = 1'b0;
        end
        grains = '0;
        run_len = '0;
        run_area = '0;
        quiet = '0;
        threshold = '0;
        n_checked = 0;
        n_errors = 0;
        n_records = 0;
        n_topples = 0;
        peak_count = 0;
    endfunction

    function bit [STAT_W-1:0] add_sat(bit [STAT_W-1:0] a, bit [STAT_W-1:0] b);
        return (a > {STAT_W{1'b1}} - b) ? {STAT_W{1'b1}} : a + b;
    endfunction

    task report(string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH: %s", msg);
    endtask

    task field_check(string name, logic [STAT_W-1:0] want, logic [STAT_W-1:0] got);
        if (want !== got)
            report($sformatf("beat %0d %s expected %0d got %0d", n_checked, name, want, got));
    endtask

    function void note_beat(op_t op, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col);
        int idx, incoming, edge_cnt, lost, h, n;
        bit prev_mark [GRID_N*GRID_N];
        grid_tally_t t;
        if (op == OP_TOPPLE) begin
            n_topples++;
            prev_mark = mark;
            lost = 0;
            for (int r = 0; r < GRID_N; r++) begin
                for (int c = 0; c < GRID_N; c++) begin
                    idx = r * GRID_N + c;
                    incoming = 0;
                    edge_cnt = 0;
                    if (r + 1 < GRID_N) incoming += prev_mark[idx + GRID_N]; else edge_cnt++;
                    if (r > 0) incoming += prev_mark[idx - GRID_N]; else edge_cnt++;
                    if (c + 1 < GRID_N) incoming += prev_mark[idx + 1]; else edge_cnt++;
                    if (c > 0) incoming += prev_mark[idx - 1]; else edge_cnt++;
                    h = height[idx];
                    if (prev_mark[idx]) begin
                        lost += edge_cnt;
                        h = (h >= 4) ? h - 4 : 0;
                    end
                    h += incoming;
                    if (h > 15) begin
                        lost += h - 15;
                        h = 15;
                    end
                    height[idx] = h[HEIGHT_W-1:0];
                    mark[idx] = (h >= 4);
                end
            end
            grains = (int'(grains) > lost) ? grains - lost[TOTAL_W-1:0] : '0;
        end else if (row < GRID_N && col < GRID_N) begin
            idx = row * GRID_N + col;
            if (height[idx] < 15) begin
                height[idx]++;
                if (grains < TOTAL_MAX)
                    grains++;
            end
            if (height[idx] >= 4)
                mark[idx] = 1'b1;
        end
        n = 0;
        foreach (mark[i])
            n += mark[i];
        if (n > 2047)
            n = 2047;
        if (n > peak_count)
            peak_count = n;
        t.count = n[COUNT_W-1:0];
        t.total = grains;
        t.rec = 1'b0;
        t.dur = '0;
        t.area = '0;
        t.quiet = '0;
        if (n > threshold) begin
            if (quiet != 0) begin
                t.rec = 1'b1;
                t.dur = run_len;
                t.area = run_area;
                t.quiet = quiet;
                quiet = '0;
                run_len = '0;
                run_area = '0;
                n_records++;
            end
            run_len = add_sat(run_len, 1);
            run_area = add_sat(run_area, n);
        end else begin
            quiet = add_sat(quiet, 1);
        end
        tally_q.insert(tally_q.size(), t);
    endfunction

    task check_tally(logic [COUNT_W-1:0] count, logic [TOTAL_W-1:0] total, logic rec,
                     logic [STAT_W-1:0] dur, logic [STAT_W-1:0] area,
                     logic [STAT_W-1:0] quiet_got);
        grid_tally_t t;
        if (tally_q.size() == 0) begin
            report($sformatf("result beat %0d with nothing expected", n_checked));
        end else begin
            t = tally_q.pop_front();
            field_check("critical_count", STAT_W'(t.count), STAT_W'(count));
            field_check("grain_total", STAT_W'(t.total), STAT_W'(total));
            field_check("record_valid", STAT_W'(t.rec), STAT_W'(rec));
            field_check("record_duration", t.dur, dur);
            field_check("record_area", t.area, area);
            field_check("record_quiet", t.quiet, quiet_got);
        end
        n_checked++;
    endtask
endclass

module tb;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [ROW_W-1:0]   s_row = '0;
    logic [ROW_W-1:0]   s_col = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COUNT_W-1:0] m_critical_count;
    logic [TOTAL_W-1:0] m_grain_total;
    logic               m_record_valid;
    logic [STAT_W-1:0]  m_record_duration;
    logic [STAT_W-1:0]  m_record_area;
    logic [STAT_W-1:0]  m_record_quiet;

    pile_scoreboard pile;
    int unsigned    items_sent = 0;
    int             hold_at_item = -1;
    int             pause_at_item = -1;
    bit             long_hold = 1'b0;
    bit             calm = 1'b0;
    int unsigned    idle_odds = 5;

    sandpile_toppling_automaton #(
        .GRID_SIZE(GRID_N)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_row             (s_row),
        .s_col             (s_col),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_critical_count  (m_critical_count),
        .m_grain_total     (m_grain_total),
        .m_record_valid    (m_record_valid),
        .m_record_duration (m_record_duration),
        .m_record_area     (m_record_area),
        .m_record_quiet    (m_record_quiet)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pile.note_beat(op_t'(s_op), s_row, s_col);
            if (m_valid && m_ready)
                pile.check_tally(m_critical_count, m_grain_total, m_record_valid,
                                 m_record_duration, m_record_area, m_record_quiet);
        end
    end

    // result side stalls
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, idle_odds) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sandpile_toppling_automaton test failed");
        $finish;
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pile.n_checked < items_sent)
            @(posedge aclk);
    endtask

    task automatic send_beat(input op_t op, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col);
        s_valid <= 1'b1;
        s_op <= op;
        s_row <= row;
        s_col <= col;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        if (items_sent == hold_at_item)
            long_hold = 1'b1;
        if (items_sent == pause_at_item)
            wait_drained();
        if (!calm && $urandom_range(0, idle_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    function automatic logic [ROW_W-1:0] near_cell(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > GRID_N - 1)
            v = GRID_N - 1;
        return v[ROW_W-1:0];
    endfunction

    // mostly grain clusters followed by topple runs, the rest scattered beats
    task automatic run_phase(input int n_items);
        int done, cr, cc, spread, n;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                cr = $urandom_range(0, GRID_N - 1);
                cc = $urandom_range(0, GRID_N - 1);
                spread = $urandom_range(0, 2);
                n = $urandom_range(3, 20);
                for (int k = 0; k < n; k++)
                    send_beat(OP_ADD, near_cell(cr, spread), near_cell(cc, spread));
                done += n;
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++)
                    send_beat(OP_TOPPLE, ROW_W'($urandom_range(0, 31)),
                              ROW_W'($urandom_range(0, 31)));
                done += n;
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_beat($urandom_range(0, 1) ? OP_TOPPLE : OP_ADD,
                              ROW_W'($urandom_range(0, 31)), ROW_W'($urandom_range(0, 31)));
                done += n;
            end
        end
    endtask

    initial begin
        int unsigned thresholds [PHASES];
        pile = new();
        thresholds = '{0, 1, 2047, 3, 1024, 0, 0, 2};
        thresholds[5] = $urandom_range(4, 60);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty grid, corner piles losing grains off the edge, interior pile
        send_beat(OP_TOPPLE, 5'd0, 5'd0);
        repeat (4) send_beat(OP_ADD, 5'd0, 5'd0);
        send_beat(OP_TOPPLE, 5'd31, 5'd31);
        repeat (4) send_beat(OP_ADD, 5'd31, 5'd31);
        send_beat(OP_TOPPLE, 5'd0, 5'd0);
        send_beat(OP_ADD, 5'd0, 5'd31);
        send_beat(OP_ADD, 5'd31, 5'd0);
        send_beat(OP_ADD, 5'd10, 5'd21);
        send_beat(OP_ADD, 5'd21, 5'd10);
        repeat (4) send_beat(OP_ADD, 5'd16, 5'd15);
        send_beat(OP_TOPPLE, 5'd21, 5'd10);
        send_beat(OP_TOPPLE, 5'd10, 5'd21);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= thresholds[ph][COUNT_W-1:0];
            pile.threshold = thresholds[ph][COUNT_W-1:0];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            idle_odds = (ph % 3 == 2) ? 40 : ((ph % 3 == 0) ? 3 : 8);
            calm = (ph == PHASES - 1);
            if (ph == 1)
                hold_at_item = items_sent + 40;
            if (ph == 3)
                pause_at_item = items_sent + 60;
            run_phase(134);
        end
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d beats (%0d topples) over %0d threshold settings",
                 pile.n_checked, pile.n_topples, PHASES);
        $display("saw %0d avalanche records, peak critical count %0d",
                 pile.n_records, pile.peak_count);
        if (pile.n_errors == 0 && pile.tally_q.size() == 0)
            $display("sandpile_toppling_automaton test passed");
        else
            $display("sandpile_toppling_automaton test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/sp_pkg.sv
rtl/sp_cell.sv
rtl/sp_count_tree.sv
rtl/sandpile_toppling_automaton.sv
rtl/sp_checker.sv
tb/tb.sv
